// ===== sv/htu_pkg.sv =====
// htu_pkg: shared widths, codes and pipeline item types for the transform unit
// no dependencies; imported by the interfaces, the divider and the top level
package htu_pkg;

   localparam int FracBits  = 16;
   localparam int DataW     = 32;
   localparam int ProdW     = 2 * DataW;
   localparam int SumW      = ProdW + 2;
   localparam int ShW       = SumW - FracBits + 1;
   localparam int DivW      = DataW + FracBits;
   localparam int FwdCount  = 16;
   localparam int InvCount  = 9;
   localparam int IdxW      = 5;

   localparam logic signed [DataW-1:0] QOne = DataW'(1) << FracBits;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_POINT  = 2'd1,
      CMD_VECTOR = 2'd2,
      CMD_NORMAL = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_VECTOR = 2'd1,
      KIND_NORMAL = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_DIV  = 2'd1,
      MODE_ZERO = 2'd2
   } out_mode_type;

   typedef struct packed {
      logic [DivW-1:0]         num;
      logic [DivW-1:0]         quo;
      logic [DataW-1:0]        rem;
      logic                    neg;
      logic signed [DataW-1:0] pass;
   } div_lane_type;

   typedef struct packed {
      kind_type              kind;
      out_mode_type          mode;
      logic [DataW-1:0]      den;
      div_lane_type [2:0]    lane;
   } div_item_type;

endpackage

// ===== sv/htu_if.sv =====
// htu_if: request and response channel interfaces with valid/ready handshake
// depends on htu_pkg
interface htu_req_if
   import htu_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic [IdxW-1:0]         coef_index;
   logic signed [DataW-1:0] coef_value;
   logic signed [DataW-1:0] in_x;
   logic signed [DataW-1:0] in_y;
   logic signed [DataW-1:0] in_z;

   modport source (output valid, command, coef_index, coef_value, in_x, in_y, in_z,
                   input ready);
   modport sink   (input valid, command, coef_index, coef_value, in_x, in_y, in_z,
                   output ready);
endinterface

interface htu_rsp_if
   import htu_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] out_x;
   logic signed [DataW-1:0] out_y;
   logic signed [DataW-1:0] out_z;
   logic [1:0]              kind;
   logic                    zero_w_error;

   modport source (output valid, out_x, out_y, out_z, kind, zero_w_error, input ready);
   modport sink   (input valid, out_x, out_y, out_z, kind, zero_w_error, output ready);
endinterface

// ===== sv/htu_div.sv =====
// htu_div: pipelined restoring divider, one quotient bit per stage, three lanes
// depends on htu_pkg
module htu_div
   import htu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output div_item_type out_item
);

   div_item_type    item_ff  [DivW];
   div_item_type    src_item [DivW];
   div_item_type    step_in  [DivW];
   logic [DivW-1:0] vld_ff;
   logic [DivW-1:0] src_vld;
   logic [DivW:0]   rdy;

   assign rdy[DivW] = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DivW-1];
   assign out_item  = item_ff[DivW-1];

   for (genvar s = 0; s < DivW; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_item[s] = in_item;
         assign src_vld[s]  = in_valid;
      end else begin : g_next
         assign src_item[s] = item_ff[s-1];
         assign src_vld[s]  = vld_ff[s-1];
      end

      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      // one shift-subtract step per lane
      always_comb begin
         logic [DataW:0] trial;
         logic           ge;
         step_in[s] = src_item[s];
         for (int l = 0; l < 3; l++) begin
            trial = {src_item[s].lane[l].rem, src_item[s].lane[l].num[DivW-1]};
            ge    = trial >= {1'b0, src_item[s].den};
            step_in[s].lane[l].rem = ge ? DataW'(trial - {1'b0, src_item[s].den})
                                        : DataW'(trial);
            step_in[s].lane[l].num = src_item[s].lane[l].num << 1;
            step_in[s].lane[l].quo = {src_item[s].lane[l].quo[DivW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= src_vld[s];
         end
         if (rdy[s] && src_vld[s]) begin
            item_ff[s] <= step_in[s];
         end
      end
   end

endmodule

// ===== sv/homogeneous_transform_unit_top.sv =====
// homogeneous_transform_unit_top: 4x4 homogeneous transform of points, vectors, normals
// depends on htu_pkg, htu_if (htu_req_if, htu_rsp_if) and htu_div
//
// path: stages 1 to 5, the divider stages, then the output register; data is Q16.16
// throughput: one transfer per cycle unless stalled; the divider takes a point every cycle
// coefficient writes produce no response and apply to the next transfer
// reset: synchronous; matrices return to identity, all pipeline valid bits clear
module homogeneous_transform_unit_top
   import htu_pkg::*;
(
   input logic      clock,
   input logic      reset,
   htu_req_if.sink  req_bus,
   htu_rsp_if.source rsp_bus
);

   // saturate a widened row sum to the signed data range
   function automatic logic signed [DataW-1:0] sat_data(input logic signed [ShW-1:0] v);
      logic signed [DataW-1:0] r;
      if (!v[ShW-1] && (|v[ShW-2:DataW-1])) begin
         r = {1'b0, {(DataW-1){1'b1}}};
      end else if (v[ShW-1] && !(&v[ShW-2:DataW-1])) begin
         r = {1'b1, {(DataW-1){1'b0}}};
      end else begin
         r = v[DataW-1:0];
      end
      return r;
   endfunction

   // coefficient storage, identity after reset
   logic signed [DataW-1:0] fwd_ff [FwdCount];
   logic signed [DataW-1:0] inv_ff [InvCount];

   // handshake chain, rdy1 is the request ready
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out, div_in_ready, div_out_valid;
   logic acc, wr_acc, xf_acc;
   command_type cmd;

   assign cmd    = command_type'(req_bus.command);
   assign acc    = req_bus.valid && req_bus.ready;
   assign wr_acc = acc && (cmd == CMD_WRITE);
   assign xf_acc = acc && (cmd != CMD_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FwdCount; i++) begin
            fwd_ff[i] <= (i % 5 == 0) ? QOne : '0;
         end
         for (int i = 0; i < InvCount; i++) begin
            inv_ff[i] <= (i % 4 == 0) ? QOne : '0;
         end
      end else if (wr_acc) begin
         for (int i = 0; i < FwdCount; i++) begin
            if (req_bus.coef_index == IdxW'(i)) begin
               fwd_ff[i] <= req_bus.coef_value;
            end
         end
         for (int i = 0; i < InvCount; i++) begin
            if (req_bus.coef_index == IdxW'(FwdCount + i)) begin
               inv_ff[i] <= req_bus.coef_value;
            end
         end
      end
   end

   // stage 1: pick coefficients for the command, row 3 is the w row
   logic signed [DataW-1:0] coef_in [4][3];
   logic signed [DataW-1:0] tr_in   [4];
   kind_type                kind_in;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         tr_in[r] = '0;
         for (int c = 0; c < 3; c++) begin
            coef_in[r][c] = fwd_ff[4*r+c];
         end
      end
      unique case (cmd)
         CMD_NORMAL: begin
            kind_in = KIND_NORMAL;
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 3; c++) begin
                  coef_in[r][c] = (r < 3) ? inv_ff[3*c+r] : '0;
               end
            end
         end
         CMD_VECTOR: begin
            kind_in = KIND_VECTOR;
         end
         default: begin
            kind_in = KIND_POINT;
            for (int r = 0; r < 4; r++) begin
               tr_in[r] = fwd_ff[4*r+3];
            end
         end
      endcase
   end

   logic                    s1_v_ff;
   kind_type                s1_kind_ff;
   logic signed [DataW-1:0] s1_xyz_ff  [3];
   logic signed [DataW-1:0] s1_coef_ff [4][3];
   logic signed [DataW-1:0] s1_tr_ff   [4];

   assign rdy1          = !s1_v_ff || rdy2;
   assign req_bus.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (rdy1) begin
         s1_v_ff <= xf_acc;
      end
      if (xf_acc) begin
         s1_kind_ff   <= kind_in;
         s1_xyz_ff[0] <= req_bus.in_x;
         s1_xyz_ff[1] <= req_bus.in_y;
         s1_xyz_ff[2] <= req_bus.in_z;
         s1_coef_ff   <= coef_in;
         s1_tr_ff     <= tr_in;
      end
   end

   // stage 2: twelve 32x32 signed products
   logic                    s2_v_ff;
   kind_type                s2_kind_ff;
   logic signed [ProdW-1:0] s2_prod_ff [4][3];
   logic signed [DataW-1:0] s2_tr_ff   [4];

   assign rdy2 = !s2_v_ff || rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (rdy2) begin
         s2_v_ff <= s1_v_ff;
      end
      if (rdy2 && s1_v_ff) begin
         s2_kind_ff <= s1_kind_ff;
         s2_tr_ff   <= s1_tr_ff;
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               s2_prod_ff[r][c] <= ProdW'(s1_coef_ff[r][c]) * ProdW'(s1_xyz_ff[c]);
            end
         end
      end
   end

   // stage 3: exact row sums, floor shift by the fraction width
   logic                         s3_v_ff;
   kind_type                     s3_kind_ff;
   logic signed [SumW-FracBits-1:0] s3_sh_ff [4];
   logic signed [DataW-1:0]      s3_tr_ff [4];
   logic signed [SumW-1:0]       row_sum [4];

   assign rdy3 = !s3_v_ff || rdy4;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         row_sum[r] = SumW'(s2_prod_ff[r][0]) + SumW'(s2_prod_ff[r][1])
                    + SumW'(s2_prod_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (rdy3) begin
         s3_v_ff <= s2_v_ff;
      end
      if (rdy3 && s2_v_ff) begin
         s3_kind_ff <= s2_kind_ff;
         s3_tr_ff   <= s2_tr_ff;
         for (int r = 0; r < 4; r++) begin
            s3_sh_ff[r] <= (SumW-FracBits)'(row_sum[r] >>> FracBits);
         end
      end
   end

   // stage 4: add translation and saturate
   logic                    s4_v_ff;
   kind_type                s4_kind_ff;
   logic signed [DataW-1:0] s4_r_ff [4];

   assign rdy4 = !s4_v_ff || rdy5;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (rdy4) begin
         s4_v_ff <= s3_v_ff;
      end
      if (rdy4 && s3_v_ff) begin
         s4_kind_ff <= s3_kind_ff;
         for (int r = 0; r < 4; r++) begin
            s4_r_ff[r] <= sat_data(ShW'(s3_sh_ff[r]) + ShW'(s3_tr_ff[r]));
         end
      end
   end

   // stage 5: w test, magnitudes and signs for the divider
   div_item_type prep;
   logic         s5_v_ff;
   div_item_type s5_item_ff;
   logic         w_neg;

   assign rdy5  = !s5_v_ff || div_in_ready;
   assign w_neg = s4_r_ff[3][DataW-1];

   always_comb begin
      logic [DataW-1:0] mag;
      prep.kind = s4_kind_ff;
      if (s4_kind_ff != KIND_POINT) begin
         prep.mode = MODE_PASS;
      end else if (s4_r_ff[3] == '0) begin
         prep.mode = MODE_ZERO;
      end else if (s4_r_ff[3] == QOne) begin
         prep.mode = MODE_PASS;
      end else begin
         prep.mode = MODE_DIV;
      end
      prep.den = w_neg ? DataW'(-s4_r_ff[3]) : DataW'(s4_r_ff[3]);
      for (int l = 0; l < 3; l++) begin
         mag = s4_r_ff[l][DataW-1] ? DataW'(-s4_r_ff[l]) : DataW'(s4_r_ff[l]);
         prep.lane[l].num  = {mag, {FracBits{1'b0}}};
         prep.lane[l].quo  = '0;
         prep.lane[l].rem  = '0;
         prep.lane[l].neg  = s4_r_ff[l][DataW-1] ^ w_neg;
         prep.lane[l].pass = s4_r_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (rdy5) begin
         s5_v_ff <= s4_v_ff;
      end
      if (rdy5 && s4_v_ff) begin
         s5_item_ff <= prep;
      end
   end

   // divider: one quotient bit per stage
   div_item_type div_out;

   htu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_v_ff),
      .in_ready  (div_in_ready),
      .in_item   (s5_item_ff),
      .out_valid (div_out_valid),
      .out_ready (rdy_out),
      .out_item  (div_out)
   );

   // output register: sign the quotient, saturate, select by mode
   logic                    out_v_ff;
   logic signed [DataW-1:0] out_r_ff [3];
   kind_type                out_kind_ff;
   logic                    out_err_ff;
   logic signed [DataW-1:0] fin [3];

   localparam logic [DivW-1:0] QuoMax = DivW'({1'b0, {(DataW-1){1'b1}}});

   assign rdy_out = !out_v_ff || rsp_bus.ready;

   always_comb begin
      logic [DivW-1:0] q;
      for (int l = 0; l < 3; l++) begin
         q = div_out.lane[l].quo;
         case (div_out.mode)
            MODE_DIV: begin
               if (div_out.lane[l].neg) begin
                  fin[l] = (q > QuoMax + DivW'(1)) ? {1'b1, {(DataW-1){1'b0}}}
                                                   : DataW'(-q);
               end else begin
                  fin[l] = (q > QuoMax) ? {1'b0, {(DataW-1){1'b1}}} : DataW'(q);
               end
            end
            MODE_ZERO: fin[l] = '0;
            default:   fin[l] = div_out.lane[l].pass;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rdy_out) begin
         out_v_ff <= div_out_valid;
      end
      if (rdy_out && div_out_valid) begin
         out_r_ff    <= fin;
         out_kind_ff <= div_out.kind;
         out_err_ff  <= (div_out.mode == MODE_ZERO);
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.out_x        = out_r_ff[0];
   assign rsp_bus.out_y        = out_r_ff[1];
   assign rsp_bus.out_z        = out_r_ff[2];
   assign rsp_bus.kind         = out_kind_ff;
   assign rsp_bus.zero_w_error = out_err_ff;

   // a zero-w error only ever comes with a zeroed point
   a_err_point: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.zero_w_error |->
         rsp_bus.kind == KIND_POINT && rsp_bus.out_x == '0 &&
         rsp_bus.out_y == '0 && rsp_bus.out_z == '0)
      else $error("zero-w error on a non-zero or non-point result");

   // coefficient writes never enter the datapath
   a_write_no_item: assert property (@(posedge clock) disable iff (reset)
      wr_acc |=> !s1_v_ff)
      else $error("coefficient write entered the pipeline");

   // a held response keeps its payload until taken
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_bus.ready |=> out_v_ff && $stable(out_r_ff[0]) &&
         $stable(out_err_ff))
      else $error("stalled response changed");

   // reset empties the output stage and stage 1
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !out_v_ff && !s1_v_ff)
      else $error("valid bit survived reset");

endmodule
